// ----- src/tca_pkg.sv -----
package tca_pkg;

   localparam int LANE_CELLS_DEF = 64;
   localparam int SPEED_BITS_DEF = 4;

   localparam int CSR_ADDR_W = 5;

   localparam logic [2:0] REG_LANE_LENGTH  = 3'd0;
   localparam logic [2:0] REG_MAX_SPEED    = 3'd1;
   localparam logic [2:0] REG_BRAKE_CHANCE = 3'd2;
   localparam logic [2:0] REG_ENTRY_CHANCE = 3'd3;
   localparam logic [2:0] REG_EXIT_CHANCE  = 3'd4;
   localparam logic [2:0] REG_RANDOM_SEED  = 3'd5;

   localparam logic [31:0] LFSR_TAPS       = 32'hD000_0001;
   localparam logic [31:0] SEED_RESET      = 32'd1;
   localparam logic [16:0] CHANCE_ONE      = 17'd65536;
   localparam logic [16:0] CHANCE_RESET    = 17'd32768;
   localparam logic [3:0]  MAX_SPEED_RESET = 4'd5;
   localparam logic [9:0]  TOTAL_SAT       = 10'd1023;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_ENTRY,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_LEAD_BRAKE,
      ST_LEAD_EXIT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic       operation;
      logic [5:0] cell_index;
   } req_payload_type;

   typedef struct packed {
      logic       cell_occupied;
      logic [3:0] cell_speed;
      logic [9:0] speed_total;
      logic [6:0] car_count;
      logic       car_entered;
      logic       car_left;
   } rsp_payload_type;

   typedef struct packed {
      logic clear_all;
      logic clr_en;
      logic set_en;
   } store_cmd_type;

   function automatic logic [16:0] clamp_chance(input logic [31:0] data);
      logic [16:0] v;
      v = data[16:0];
      return (v > CHANCE_ONE) ? CHANCE_ONE : v;
   endfunction

endpackage

// ----- src/tca_draw_unit.sv -----
module tca_draw_unit import tca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        seed_load,
   input  logic [31:0] seed,
   input  logic        step,
   input  logic [16:0] chance,
   output logic        fire
);

   logic [31:0] lfsr_ff;
   logic [31:0] lfsr_in;
   logic [31:0] lfsr_next;
   logic [31:0] seed_val;

   assign lfsr_next = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 32'd0);
   assign seed_val  = (seed == 32'd0) ? 32'd1 : seed;
   assign fire      = {1'b0, lfsr_next[15:0]} < chance;

   always_comb begin
      lfsr_in = lfsr_ff;
      if (seed_load) begin
         lfsr_in = seed_val;
      end else if (step) begin
         lfsr_in = lfsr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= SEED_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

endmodule

// ----- src/tca_lane_store.sv -----
module tca_lane_store import tca_pkg::*; #(
   parameter  int LANE_CELLS = LANE_CELLS_DEF,
   parameter  int SPEED_BITS = SPEED_BITS_DEF,
   localparam int IDX_W      = $clog2(LANE_CELLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  store_cmd_type         cmd,
   input  logic [IDX_W-1:0]      clr_addr,
   input  logic [IDX_W-1:0]      set_addr,
   input  logic [SPEED_BITS-1:0] set_vel,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic                  rd_occ,
   output logic [SPEED_BITS-1:0] rd_vel,
   output logic                  head_occ
);

   logic [LANE_CELLS-1:0] occ_ff;
   logic [LANE_CELLS-1:0] occ_in;
   logic [SPEED_BITS-1:0] vel_mem [LANE_CELLS];
   logic [SPEED_BITS-1:0] rd_vel_ff;
   logic                  rd_occ_ff;

   assign rd_occ   = rd_occ_ff;
   assign rd_vel   = rd_vel_ff;
   assign head_occ = occ_ff[0];

   // set wins over clear, so a car that stands still keeps its cell
   always_comb begin
      occ_in = occ_ff;
      if (cmd.clear_all) begin
         occ_in = '0;
      end else begin
         if (cmd.clr_en) begin
            occ_in[clr_addr] = 1'b0;
         end
         if (cmd.set_en) begin
            occ_in[set_addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_en) begin
         vel_mem[set_addr] <= set_vel;
      end
      rd_vel_ff <= vel_mem[rd_addr];
      rd_occ_ff <= occ_ff[rd_addr];
   end

endmodule

// ----- src/tca_sequencer.sv -----
module tca_sequencer import tca_pkg::*; #(
   parameter  int LANE_CELLS = LANE_CELLS_DEF,
   parameter  int SPEED_BITS = SPEED_BITS_DEF,
   localparam int IDX_W      = $clog2(LANE_CELLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic [6:0]            lane_length,
   input  logic [3:0]            max_speed,
   input  logic [16:0]           brake_chance,
   input  logic [16:0]           entry_chance,
   input  logic [16:0]           exit_chance,
   input  logic                  clear_lane,
   output logic                  draw_step,
   output logic [16:0]           draw_chance,
   input  logic                  draw_fire,
   output store_cmd_type         cmd,
   output logic [IDX_W-1:0]      clr_addr,
   output logic [IDX_W-1:0]      set_addr,
   output logic [SPEED_BITS-1:0] set_vel,
   output logic [IDX_W-1:0]      rd_addr,
   input  logic                  rd_occ,
   input  logic [SPEED_BITS-1:0] rd_vel,
   input  logic                  head_occ,
   output rsp_payload_type       res,
   output logic                  res_valid,
   input  logic                  res_take
);

   localparam int PW = ((IDX_W > 7) ? IDX_W : 7) + 1;

   seq_state_type state_ff, state_in;

   logic [PW-1:0]         idx_ff;
   logic [PW-1:0]         ppos_ff;
   logic [SPEED_BITS-1:0] pvel_ff;
   logic                  pend_ff;
   logic [PW-1:0]         leadv_ff;
   logic [PW-1:0]         ncars_ff;
   logic [PW-1:0]         cars_ff;
   logic [9:0]            total_ff;
   logic                  entered_ff;
   logic                  left_ff;
   logic                  op_ff;
   logic [5:0]            cell_index_ff;
   logic                  rd_occ_ff;
   logic [3:0]            rd_spd_ff;

   logic [PW-1:0] lane_w;
   logic [PW-1:0] max_w;
   logic [PW-1:0] last_pos;
   logic [PW-1:0] gap;
   logic [PW-1:0] v_acc;
   logic [PW-1:0] v_cap;
   logic [PW-1:0] v_gap;
   logic [PW-1:0] vnew;
   logic [PW-1:0] npos;
   logic [10:0]   tot_sum;
   logic [9:0]    tot_next;
   logic          entry_go;
   logic          scan_last;
   logic          lead_out;
   logic          in_range;

   assign lane_w   = PW'(lane_length);
   assign max_w    = PW'(max_speed);
   assign last_pos = lane_w - PW'(1);

   // one car update: accelerate, cap at top speed and gap, brake on a draw
   always_comb begin
      gap   = (state_ff == ST_LEAD_BRAKE) ? max_w : (idx_ff - ppos_ff - PW'(1));
      v_acc = PW'(pvel_ff) + PW'(1);
      v_cap = (v_acc > max_w) ? max_w : v_acc;
      v_gap = (v_cap > gap) ? gap : v_cap;
      vnew  = (draw_fire && (v_gap != '0)) ? (v_gap - PW'(1)) : v_gap;
      npos  = ppos_ff + vnew;
   end

   assign tot_sum   = {1'b0, total_ff} + 11'(vnew);
   assign tot_next  = tot_sum[10] ? TOTAL_SAT : tot_sum[9:0];
   assign entry_go  = (cars_ff < lane_w) && !head_occ && (entry_chance != '0);
   assign scan_last = (idx_ff == last_pos);
   assign lead_out  = (npos >= lane_w);
   assign in_range  = PW'(cell_index_ff) < PW'(LANE_CELLS);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_payload.operation ? ST_RD_ISSUE : ST_ENTRY;
            end
         end
         ST_RD_ISSUE:  state_in = ST_RD_DATA;
         ST_RD_DATA:   state_in = ST_DONE;
         ST_ENTRY:     state_in = ST_SCAN_RD;
         ST_SCAN_RD:   state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (scan_last) begin
               state_in = (rd_occ || pend_ff) ? ST_LEAD_BRAKE : ST_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_LEAD_BRAKE: begin
            state_in = (lead_out && (exit_chance != '0)) ? ST_LEAD_EXIT : ST_DONE;
         end
         ST_LEAD_EXIT: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      res_valid     = (state_ff == ST_DONE);
      draw_step     = 1'b0;
      draw_chance   = brake_chance;
      cmd.clear_all = clear_lane;
      cmd.clr_en    = 1'b0;
      cmd.set_en    = 1'b0;
      clr_addr      = ppos_ff[IDX_W-1:0];
      set_addr      = npos[IDX_W-1:0];
      set_vel       = SPEED_BITS'(vnew);
      rd_addr       = idx_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_RD_ISSUE: begin
            rd_addr = IDX_W'(cell_index_ff);
         end
         ST_ENTRY: begin
            draw_step   = entry_go;
            draw_chance = entry_chance;
            cmd.set_en  = entry_go && draw_fire;
            set_addr    = '0;
            set_vel     = '0;
         end
         ST_SCAN_CHK: begin
            draw_step  = rd_occ && pend_ff;
            cmd.clr_en = rd_occ && pend_ff;
            cmd.set_en = rd_occ && pend_ff;
         end
         ST_LEAD_BRAKE: begin
            draw_step = 1'b1;
            if (!lead_out) begin
               cmd.clr_en = 1'b1;
               cmd.set_en = 1'b1;
            end else if (exit_chance == '0) begin
               // no exit possible: park in the last cell
               cmd.clr_en = 1'b1;
               cmd.set_en = 1'b1;
               set_addr   = last_pos[IDX_W-1:0];
            end
         end
         ST_LEAD_EXIT: begin
            draw_step   = 1'b1;
            draw_chance = exit_chance;
            cmd.clr_en  = 1'b1;
            cmd.set_en  = !draw_fire;
            set_addr    = last_pos[IDX_W-1:0];
            set_vel     = SPEED_BITS'(leadv_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cars_ff    <= '0;
         pend_ff    <= 1'b0;
         entered_ff <= 1'b0;
         left_ff    <= 1'b0;
         op_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clear_lane) begin
            cars_ff <= '0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_payload.operation;
                  cell_index_ff <= req_payload.cell_index;
                  idx_ff        <= '0;
                  pend_ff       <= 1'b0;
                  ncars_ff      <= '0;
                  total_ff      <= '0;
                  entered_ff    <= 1'b0;
                  left_ff       <= 1'b0;
               end
            end
            ST_RD_DATA: begin
               rd_occ_ff <= rd_occ && in_range;
               rd_spd_ff <= (rd_occ && in_range) ? 4'(rd_vel) : 4'd0;
            end
            ST_ENTRY: begin
               entered_ff <= entry_go && draw_fire;
            end
            ST_SCAN_CHK: begin
               if (rd_occ) begin
                  if (pend_ff) begin
                     total_ff <= tot_next;
                  end
                  ppos_ff  <= idx_ff;
                  pvel_ff  <= rd_vel;
                  pend_ff  <= 1'b1;
                  ncars_ff <= ncars_ff + PW'(1);
               end
               if (scan_last) begin
                  cars_ff <= ncars_ff + PW'(rd_occ);
               end
               idx_ff <= idx_ff + PW'(1);
            end
            ST_LEAD_BRAKE: begin
               total_ff <= tot_next;
               leadv_ff <= vnew;
            end
            ST_LEAD_EXIT: begin
               left_ff <= draw_fire;
               if (draw_fire) begin
                  cars_ff <= cars_ff - PW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res.cell_occupied = op_ff ? rd_occ_ff : 1'b0;
      res.cell_speed    = op_ff ? rd_spd_ff : 4'd0;
      res.speed_total   = op_ff ? 10'd0 : total_ff;
      res.car_count     = 7'(cars_ff);
      res.car_entered   = op_ff ? 1'b0 : entered_ff;
      res.car_left      = op_ff ? 1'b0 : left_ff;
   end

endmodule

// ----- src/traffic_cellular_automaton_lane_unit.sv -----
// Channel   Direction  Handshake              Carries
// req_      in         req_valid/req_ready    operation, cell_index
// rsp_      out        rsp_valid/rsp_ready    cell fields, step totals, flags
// csr_      in         APB write/read         six registers at 4*i
//
// A read request issues a memory read and then registers the cell data. An
// advance request makes an entry draw, then a memory read and a check per cell;
// a lead car adds a brake draw, and an exit draw may follow if it runs off.
// Reset empties the lane at once through per-cell occupancy flops.
// A result waits in the output register while the next request is taken.
module traffic_cellular_automaton_lane_unit import tca_pkg::*; #(
   parameter int LANE_CELLS = LANE_CELLS_DEF,
   parameter int SPEED_BITS = SPEED_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W     = $clog2(LANE_CELLS);
   localparam int SPEED_TOP = ((2 ** SPEED_BITS) - 1 < 15) ? (2 ** SPEED_BITS) - 1 : 15;
   localparam int LANE_LIM  = (LANE_CELLS < 127) ? LANE_CELLS : 127;
   localparam logic [6:0] LANE_TOP   = 7'(LANE_LIM);
   localparam logic [6:0] LANE_RESET = 7'((LANE_CELLS < 64) ? LANE_CELLS : 64);
   localparam logic [3:0] SPEED_CAP  = 4'(SPEED_TOP);
   localparam logic [3:0] SPEED_RST  = (MAX_SPEED_RESET > SPEED_CAP) ? SPEED_CAP
                                                                    : MAX_SPEED_RESET;

   logic [6:0]  lane_length_ff, lane_length_in;
   logic [3:0]  max_speed_ff, max_speed_in;
   logic [16:0] brake_chance_ff, brake_chance_in;
   logic [16:0] entry_chance_ff, entry_chance_in;
   logic [16:0] exit_chance_ff, exit_chance_in;
   logic [31:0] random_seed_ff, random_seed_in;

   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic [6:0]  wr_lane;
   logic [3:0]  wr_speed;
   logic        clear_lane;
   logic        seed_load;

   logic                  draw_step;
   logic [16:0]           draw_chance;
   logic                  draw_fire;
   store_cmd_type         cmd;
   logic [IDX_W-1:0]      clr_addr;
   logic [IDX_W-1:0]      set_addr;
   logic [SPEED_BITS-1:0] set_vel;
   logic [IDX_W-1:0]      rd_addr;
   logic                  rd_occ;
   logic [SPEED_BITS-1:0] rd_vel;
   logic                  head_occ;
   rsp_payload_type       res;
   logic                  res_valid;
   logic                  res_take;

   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign clear_lane = csr_wr && (csr_idx == REG_LANE_LENGTH);
   assign seed_load  = csr_wr && (csr_idx == REG_RANDOM_SEED);

   // saturate written values into their legal ranges
   always_comb begin
      wr_lane = csr_pwdata[6:0];
      if (wr_lane < 7'd2) begin
         wr_lane = 7'd2;
      end else if (wr_lane > LANE_TOP) begin
         wr_lane = LANE_TOP;
      end
      wr_speed = csr_pwdata[3:0];
      if (wr_speed == 4'd0) begin
         wr_speed = 4'd1;
      end else if (wr_speed > SPEED_CAP) begin
         wr_speed = SPEED_CAP;
      end
   end

   always_comb begin
      lane_length_in  = lane_length_ff;
      max_speed_in    = max_speed_ff;
      brake_chance_in = brake_chance_ff;
      entry_chance_in = entry_chance_ff;
      exit_chance_in  = exit_chance_ff;
      random_seed_in  = random_seed_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_LANE_LENGTH:  lane_length_in  = wr_lane;
            REG_MAX_SPEED:    max_speed_in    = wr_speed;
            REG_BRAKE_CHANCE: brake_chance_in = clamp_chance(csr_pwdata);
            REG_ENTRY_CHANCE: entry_chance_in = clamp_chance(csr_pwdata);
            REG_EXIT_CHANCE:  exit_chance_in  = clamp_chance(csr_pwdata);
            REG_RANDOM_SEED:  random_seed_in  = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_length_ff  <= LANE_RESET;
         max_speed_ff    <= SPEED_RST;
         brake_chance_ff <= CHANCE_RESET;
         entry_chance_ff <= CHANCE_RESET;
         exit_chance_ff  <= CHANCE_RESET;
         random_seed_ff  <= SEED_RESET;
      end else begin
         lane_length_ff  <= lane_length_in;
         max_speed_ff    <= max_speed_in;
         brake_chance_ff <= brake_chance_in;
         entry_chance_ff <= entry_chance_in;
         exit_chance_ff  <= exit_chance_in;
         random_seed_ff  <= random_seed_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_LANE_LENGTH:  csr_prdata = 32'(lane_length_ff);
         REG_MAX_SPEED:    csr_prdata = 32'(max_speed_ff);
         REG_BRAKE_CHANCE: csr_prdata = 32'(brake_chance_ff);
         REG_ENTRY_CHANCE: csr_prdata = 32'(entry_chance_ff);
         REG_EXIT_CHANCE:  csr_prdata = 32'(exit_chance_ff);
         REG_RANDOM_SEED:  csr_prdata = random_seed_ff;
         default:          csr_prdata = 32'd0;
      endcase
   end

   tca_draw_unit u_draw (
      .clock     (clock),
      .reset     (reset),
      .seed_load (seed_load),
      .seed      (csr_pwdata),
      .step      (draw_step),
      .chance    (draw_chance),
      .fire      (draw_fire)
   );

   tca_lane_store #(
      .LANE_CELLS (LANE_CELLS),
      .SPEED_BITS (SPEED_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .clr_addr (clr_addr),
      .set_addr (set_addr),
      .set_vel  (set_vel),
      .rd_addr  (rd_addr),
      .rd_occ   (rd_occ),
      .rd_vel   (rd_vel),
      .head_occ (head_occ)
   );

   tca_sequencer #(
      .LANE_CELLS (LANE_CELLS),
      .SPEED_BITS (SPEED_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .lane_length  (lane_length_ff),
      .max_speed    (max_speed_ff),
      .brake_chance (brake_chance_ff),
      .entry_chance (entry_chance_ff),
      .exit_chance  (exit_chance_ff),
      .clear_lane   (clear_lane),
      .draw_step    (draw_step),
      .draw_chance  (draw_chance),
      .draw_fire    (draw_fire),
      .cmd          (cmd),
      .clr_addr     (clr_addr),
      .set_addr     (set_addr),
      .set_vel      (set_vel),
      .rd_addr      (rd_addr),
      .rd_occ       (rd_occ),
      .rd_vel       (rd_vel),
      .head_occ     (head_occ),
      .res          (res),
      .res_valid    (res_valid),
      .res_take     (res_take)
   );

   // hold the result until taken; load a new one once the slot frees
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
